### rtl/core/mf_pkg.sv
// Shared types, sizes and register codes of the 3x3 median filter.
package mf_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int TAPS       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(7);
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(7);
    localparam logic [CFG_W-1:0] IMAGE_MIN_SIZE     = CFG_W'(3);

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CFG_W-1:0]   size_t;

    // Nine window pixels, three columns of three, oldest column first.
    typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;

    // Three pixels, index 0 smallest once sorted.
    typedef logic [2:0][PIX_W-1:0] trio_t;

    // Position and end-of-frame mark that travel with one result.
    typedef struct packed {
        coord_t row;
        coord_t col;
        logic   last;
    } tag_t;

endpackage

### rtl/core/mf_if.sv
// Stream and configuration interfaces of the 3x3 median filter.
interface mf_pix_if;
    logic          valid;
    logic          ready;
    mf_pkg::pix_t  pixel;
    logic          frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface mf_res_if;
    logic           valid;
    logic           ready;
    mf_pkg::pix_t   median_value;
    mf_pkg::coord_t centre_row;
    mf_pkg::coord_t centre_col;
    logic           last;

    modport source (output valid, output median_value, output centre_row,
                    output centre_col, output last, input ready);
    modport sink   (input valid, input median_value, input centre_row,
                    input centre_col, input last, output ready);
endinterface

interface mf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mf_pkg::CFG_IDX_W-1:0]   index;
    logic [mf_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/mf_line_ram.sv
// Simple dual-port line RAM with registered read.
module mf_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/mf_median_pipe.sv
// Pipelined median-of-nine network with output register.
module mf_median_pipe (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          taps_valid,
    output logic          taps_ready,
    input  mf_pkg::taps_t taps,
    input  mf_pkg::tag_t  tag,
    mf_res_if.source      res
);

    function automatic mf_pkg::pix_t min2(input mf_pkg::pix_t a, input mf_pkg::pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf_pkg::pix_t max2(input mf_pkg::pix_t a, input mf_pkg::pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf_pkg::trio_t sort3(input mf_pkg::pix_t a, input mf_pkg::pix_t b,
                                            input mf_pkg::pix_t c);
        mf_pkg::pix_t lo1;
        mf_pkg::pix_t hi1;
        mf_pkg::pix_t lo2;
        mf_pkg::trio_t s;
        lo1  = min2(a, b);
        hi1  = max2(a, b);
        lo2  = min2(hi1, c);
        s[2] = max2(hi1, c);
        s[1] = max2(lo1, lo2);
        s[0] = min2(lo1, lo2);
        return s;
    endfunction

    function automatic mf_pkg::pix_t med3(input mf_pkg::pix_t a, input mf_pkg::pix_t b,
                                          input mf_pkg::pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Stage A: captured window.
    logic          a_valid_reg, a_valid_next;
    mf_pkg::taps_t a_taps_reg;
    mf_pkg::tag_t  a_tag_reg;
    // Stage B: each column sorted.
    logic          b_valid_reg, b_valid_next;
    mf_pkg::trio_t b_col_reg [3];
    mf_pkg::tag_t  b_tag_reg;
    // Stage C: max of lows, median of middles, min of highs.
    logic          c_valid_reg, c_valid_next;
    mf_pkg::pix_t  c_lo_reg, c_mid_reg, c_hi_reg;
    mf_pkg::tag_t  c_tag_reg;
    // Output register.
    logic          out_valid_reg, out_valid_next;
    mf_pkg::pix_t  out_med_reg;
    mf_pkg::tag_t  out_tag_reg;

    logic out_load, c_free, b_go, b_free, a_go, taps_accept;

    assign out_load    = c_valid_reg && (!out_valid_reg || res.ready);
    assign c_free      = !c_valid_reg || out_load;
    assign b_go        = b_valid_reg && c_free;
    assign b_free      = !b_valid_reg || b_go;
    assign a_go        = a_valid_reg && b_free;
    assign taps_ready  = !a_valid_reg || a_go;
    assign taps_accept = taps_valid && taps_ready;

    always_comb
    begin
        a_valid_next   = taps_accept || (a_valid_reg && !a_go);
        b_valid_next   = a_go || (b_valid_reg && !b_go);
        c_valid_next   = b_go || (c_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (taps_accept)
        begin
            a_taps_reg <= taps;
            a_tag_reg  <= tag;
        end
        if (a_go)
        begin
            for (int k = 0; k < 3; k++)
            begin
                b_col_reg[k] <= sort3(a_taps_reg[3*k], a_taps_reg[3*k+1], a_taps_reg[3*k+2]);
            end
            b_tag_reg <= a_tag_reg;
        end
        if (b_go)
        begin
            c_lo_reg  <= max2(max2(b_col_reg[0][0], b_col_reg[1][0]), b_col_reg[2][0]);
            c_mid_reg <= med3(b_col_reg[0][1], b_col_reg[1][1], b_col_reg[2][1]);
            c_hi_reg  <= min2(min2(b_col_reg[0][2], b_col_reg[1][2]), b_col_reg[2][2]);
            c_tag_reg <= b_tag_reg;
        end
        if (out_load)
        begin
            out_med_reg <= med3(c_lo_reg, c_mid_reg, c_hi_reg);
            out_tag_reg <= c_tag_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.median_value = out_med_reg;
    assign res.centre_row   = out_tag_reg.row;
    assign res.centre_col   = out_tag_reg.col;
    assign res.last         = out_tag_reg.last;

    a_hold_c_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && out_valid_reg && !res.ready |=> c_valid_reg)
        else $error("stage C dropped an item while the output stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> res.valid)
        else $error("loaded result not presented");

    a_median_is_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (res.median_value == $past(c_lo_reg)
                      || res.median_value == $past(c_mid_reg)
                      || res.median_value == $past(c_hi_reg)))
        else $error("median is none of the three candidates");

endmodule

### rtl/core/median_filter_3x3.sv
// Top level of the streaming 3x3 median filter.
//
// Pixels enter in raster order, one item per clock, and the block sustains one
// item per cycle whenever the result side keeps up. Each accepted pixel reads
// its column of a single line RAM that holds the two previous rows side by
// side; the read data returns in the next cycle, and the pixel writes the
// shifted column back to the same address when it moves on and joins a
// six-pixel window of the two earlier columns. Only positions with row and
// column of at least two produce a result: the median of the nine pixels
// around (row-1, col-1), computed in a four-stage pipeline behind the RAM
// (stages A, B, C and the output register); a result is held there while
// the result side holds ready low.
// "last" marks the centre (height-2, width-2).
// Border pixels give no result. A pixel with frame_start set is placed at row
// 0, column 0; otherwise the counters wrap at the end of each row and frame.
// The line RAM has no reset; the first two rows of a frame fill it before any
// of it is used. Width and height are clamped to 3..1024 when written and
// must only be written while no item is in flight.
module median_filter_3x3 (
    input  logic     clk,
    input  logic     rst_n,
    mf_pix_if.sink   pix,
    mf_res_if.source res,
    mf_cfg_if.sink   cfg
);

    function automatic mf_pkg::size_t clamp_size(input mf_pkg::size_t v,
                                                 input mf_pkg::size_t hi);
        mf_pkg::size_t r;
        r = v;
        if (v < mf_pkg::IMAGE_MIN_SIZE)
        begin
            r = mf_pkg::IMAGE_MIN_SIZE;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers: always ready, clamp on write.
    // ------------------------------------------------------------------
    mf_pkg::size_t width_reg, width_next;
    mf_pkg::size_t height_reg, height_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mf_pkg::REG_IMAGE_WIDTH:
                    width_next = clamp_size(cfg.data, mf_pkg::CFG_W'(mf_pkg::MAX_WIDTH));
                mf_pkg::REG_IMAGE_HEIGHT:
                    height_next = clamp_size(cfg.data, mf_pkg::CFG_W'(mf_pkg::MAX_HEIGHT));
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Position counters, updated at each accepted pixel.
    // ------------------------------------------------------------------
    mf_pkg::coord_t row_count_reg, row_count_next;
    mf_pkg::coord_t col_count_reg, col_count_next;
    mf_pkg::coord_t r_cur, c_cur;
    mf_pkg::size_t  r_inc, c_inc;
    logic           pix_accept;
    logic           emit_cur;
    mf_pkg::tag_t   tag_cur;
    logic [mf_pkg::ADDR_W-1:0] rd_addr;

    assign pix_accept = pix.valid && pix.ready;
    assign r_cur      = pix.frame_start ? '0 : row_count_reg;
    assign c_cur      = pix.frame_start ? '0 : col_count_reg;
    assign r_inc      = {1'b0, r_cur} + mf_pkg::CFG_W'(1);
    assign c_inc      = {1'b0, c_cur} + mf_pkg::CFG_W'(1);
    assign rd_addr    = c_cur[mf_pkg::ADDR_W-1:0];
    assign emit_cur   = (r_cur >= mf_pkg::COORD_W'(2)) && (c_cur >= mf_pkg::COORD_W'(2));

    always_comb
    begin
        tag_cur.row  = r_cur - mf_pkg::COORD_W'(1);
        tag_cur.col  = c_cur - mf_pkg::COORD_W'(1);
        tag_cur.last = (r_inc == height_reg) && (c_inc == width_reg);
    end

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (pix_accept)
        begin
            if (c_inc >= width_reg)
            begin
                // End of row: wrap the column, advance or wrap the row.
                col_count_next = '0;
                row_count_next = (r_inc >= height_reg) ? '0 : r_inc[mf_pkg::COORD_W-1:0];
            end
            else
            begin
                col_count_next = c_inc[mf_pkg::COORD_W-1:0];
                row_count_next = ({1'b0, r_cur} >= height_reg) ? '0 : r_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // Memory stage: the pixel waits here for its column of the line RAM,
    // then writes the shifted column back and enters the window.
    // ------------------------------------------------------------------
    logic                      s1_valid_reg, s1_valid_next;
    mf_pkg::pix_t              s1_pixel_reg;
    logic [mf_pkg::ADDR_W-1:0] s1_addr_reg;
    logic                      s1_emit_reg;
    mf_pkg::tag_t              s1_tag_reg;
    logic                      s1_fwd_reg;
    mf_pkg::pix_t              fwd_top_reg, fwd_mid_reg;
    logic                      s1_go;
    logic                      fwd_cur;
    logic                      taps_ready;
    logic                      taps_valid;
    mf_pkg::taps_t             taps;
    mf_pkg::pix_t              top_s1, mid_s1;
    logic [2*mf_pkg::PIX_W-1:0] ram_rdata;
    mf_pkg::pix_t              win_reg [6];

    // Results go to the median pipe; a border pixel leaves without one.
    assign s1_go      = s1_valid_reg && (!s1_emit_reg || taps_ready);
    assign pix.ready  = !s1_valid_reg || s1_go;
    assign taps_valid = s1_valid_reg && s1_emit_reg;

    // A new pixel that reads the column being written this cycle (only after
    // frame_start restarts at the same column) gets the written data instead.
    assign fwd_cur = s1_go && (s1_addr_reg == rd_addr);

    assign top_s1 = s1_fwd_reg ? fwd_top_reg : ram_rdata[2*mf_pkg::PIX_W-1:mf_pkg::PIX_W];
    assign mid_s1 = s1_fwd_reg ? fwd_mid_reg : ram_rdata[mf_pkg::PIX_W-1:0];

    assign s1_valid_next = pix_accept || (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= mf_pkg::IMAGE_WIDTH_RESET;
            height_reg    <= mf_pkg::IMAGE_HEIGHT_RESET;
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            s1_valid_reg  <= s1_valid_next;
            if (s1_go)
            begin
                // Shift the window by one column.
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_s1;
                win_reg[4] <= mid_s1;
                win_reg[5] <= s1_pixel_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg <= pix.pixel;
            s1_addr_reg  <= rd_addr;
            s1_emit_reg  <= emit_cur;
            s1_tag_reg   <= tag_cur;
            s1_fwd_reg   <= fwd_cur;
            fwd_top_reg  <= mid_s1;
            fwd_mid_reg  <= s1_pixel_reg;
        end
    end

    // Upper row in the high byte, middle row in the low byte.
    mf_line_ram #(
        .DEPTH (mf_pkg::MAX_WIDTH),
        .WIDTH (2 * mf_pkg::PIX_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata ({mid_s1, s1_pixel_reg}),
        .re    (pix_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            taps[k] = win_reg[k];
        end
        taps[6] = top_s1;
        taps[7] = mid_s1;
        taps[8] = s1_pixel_reg;
    end

    mf_median_pipe u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .taps_valid (taps_valid),
        .taps_ready (taps_ready),
        .taps       (taps),
        .tag        (s1_tag_reg),
        .res        (res)
    );

    a_forward_on_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_accept && s1_go && (s1_addr_reg == rd_addr) |=> s1_fwd_reg && s1_valid_reg)
        else $error("same-column read and write without forwarding");

    a_result_interior: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_emit_reg |-> (s1_tag_reg.row != '0) && (s1_tag_reg.col != '0))
        else $error("result issued for a border position");

    a_last_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_emit_reg && s1_tag_reg.last
            |-> ({1'b0, s1_tag_reg.col} + mf_pkg::CFG_W'(2) == width_reg))
        else $error("last flag away from the final interior column");

endmodule
